### src/assert_macros.svh
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

### src/tas_pkg.sv
// Types, constants and helper functions of the thick arc pixel scanner.
package tas_pkg;

	localparam int OFS_W      = 12;
	localparam int CX_W       = 11;
	localparam int RAD_W      = 10;
	localparam int ANG_IN_W   = 11;
	localparam int START_W    = 9;
	localparam int PIX_W      = 13;
	localparam int IDX_W      = 3;
	localparam int DATA_W     = 11;
	localparam int MAG_W      = 11;
	localparam int PRESHIFT   = 24;
	localparam int XY_W       = MAG_W + PRESHIFT + 2;
	localparam int Z_W        = 25;
	localparam int ATAN_W     = 22;
	localparam int ATAN_IDX_W = 5;
	localparam int MUL_W      = 13;
	localparam int SQ_W       = 24;
	localparam int QUEUE_DEPTH = 2;
	localparam int Q_PTR_W    = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [IDX_W-1:0] {
		REG_CENTER_X       = 3'd0,
		REG_CENTER_Y       = 3'd1,
		REG_RING_RADIUS    = 3'd2,
		REG_RING_THICKNESS = 3'd3,
		REG_START_ANGLE    = 3'd4,
		REG_SWEEP_ANGLE    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [CX_W-1:0]            center_x;
		logic [CX_W-1:0]            center_y;
		logic [RAD_W-1:0]           radius;
		logic [RAD_W-1:0]           thickness;
		logic [START_W-1:0]         start_mod;
		logic signed [ANG_IN_W-1:0] sweep;
		logic                       degen;
	} cfg_t;

	typedef struct packed {
		logic signed [OFS_W-1:0] dx;
		logic signed [OFS_W-1:0] dy;
		logic                    last;
		logic                    degen;
	} item_t;

	function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		unique case (idx)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234378;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	// reduce a signed degree value into 0..359
	function automatic logic [START_W-1:0] start_mod(input logic [ANG_IN_W-1:0] s);
		logic [11:0] v;
		v = {s[ANG_IN_W-1], s} + 12'd1080;
		for (int k = 0; k < 5; k++) begin
			if (v >= 12'd360) begin
				v = v - 12'd360;
			end
		end
		return v[START_W-1:0];
	endfunction

endpackage

### src/tas_front.sv
// Front end: takes tick requests, walks the scan square and queues offsets.
`include "assert_macros.svh"
module tas_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          advance,
	input  tas_pkg::cfg_t cfg,
	input  logic          restart,
	input  logic          q_full,
	output logic          push,
	output tas_pkg::item_t push_item
);

	logic [tas_pkg::RAD_W:0]          half;
	logic signed [tas_pkg::OFS_W-1:0] reach;
	logic signed [tas_pkg::OFS_W-1:0] neg_reach;
	logic signed [tas_pkg::OFS_W-1:0] col_q;
	logic signed [tas_pkg::OFS_W-1:0] row_q;
	logic                             restart_q;
	logic signed [tas_pkg::OFS_W-1:0] cur_dx;
	logic signed [tas_pkg::OFS_W-1:0] cur_dy;
	logic                             cur_last;

	assign half = ({1'b0, cfg.thickness} + (tas_pkg::RAD_W + 1)'(1)) >> 1;
	assign reach = tas_pkg::OFS_W'(cfg.radius) + tas_pkg::OFS_W'(half)
		+ tas_pkg::OFS_W'(1);
	assign neg_reach = -reach;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready && advance;

	assign cur_dx   = restart_q ? neg_reach : col_q;
	assign cur_dy   = restart_q ? neg_reach : row_q;
	assign cur_last = (cur_dx == reach) && (cur_dy == reach);

	always_comb begin
		if (cfg.degen) begin
			push_item.dx    = '0;
			push_item.dy    = '0;
			push_item.last  = 1'b1;
			push_item.degen = 1'b1;
		end else begin
			push_item.dx    = cur_dx;
			push_item.dy    = cur_dy;
			push_item.last  = cur_last;
			push_item.degen = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_q <= 1'b1;
			col_q     <= '0;
			row_q     <= '0;
		end else if (restart) begin
			restart_q <= 1'b1;
		end else if (push && !cfg.degen) begin
			priority if (cur_last) begin
				restart_q <= 1'b1;
			end else if (cur_dx == reach) begin
				restart_q <= 1'b0;
				col_q     <= neg_reach;
				row_q     <= tas_pkg::OFS_W'(cur_dy + 12'sd1);
			end else begin
				restart_q <= 1'b0;
				col_q     <= tas_pkg::OFS_W'(cur_dx + 12'sd1);
				row_q     <= cur_dy;
			end
		end
	end

	`ASSERT_IMPLY(a_front_in_reach, clk, arst_n, push && !cfg.degen,
		(cur_dx >= neg_reach) && (cur_dx <= reach) && (cur_dy >= neg_reach) && (cur_dy <= reach))

endmodule

### src/tas_queue.sv
// Short request queue between the scan front end and the pixel test engine.
`include "assert_macros.svh"
module tas_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tas_pkg::item_t push_item,
	input  logic           pop,
	output tas_pkg::item_t pop_item,
	output logic           full,
	output logic           empty
);

	tas_pkg::item_t                mem [tas_pkg::QUEUE_DEPTH];
	logic [tas_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [tas_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [tas_pkg::Q_CNT_W-1:0]   count_q;

	assign full     = (count_q == tas_pkg::Q_CNT_W'(tas_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == tas_pkg::Q_PTR_W'(tas_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + tas_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == tas_pkg::Q_PTR_W'(tas_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + tas_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + tas_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - tas_pkg::Q_CNT_W'(1);
			end
		end
	end

	`ASSERT_IMPLY(a_queue_no_overflow, clk, arst_n, push, !full || pop)

endmodule

### src/tas_back.sv
// Pixel test engine: ring band check, iterative CORDIC angle, sweep check.
`include "assert_macros.svh"
module tas_back #(
	parameter int ANGLE_FRAC_BITS = 8,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tas_pkg::cfg_t                     cfg,
	input  logic                              q_empty,
	output logic                              pop,
	input  tas_pkg::item_t                    pop_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tas_pkg::PIX_W-1:0]  pixel_x,
	output logic signed [tas_pkg::PIX_W-1:0]  pixel_y,
	output logic                              hit,
	output logic                              last
);

	localparam int ANG_W  = ANGLE_FRAC_BITS + 12;
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam int ZSH    = 16 - ANGLE_FRAC_BITS;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
	localparam logic signed [tas_pkg::Z_W-1:0] RND =
		tas_pkg::Z_W'(1 << (15 - ANGLE_FRAC_BITS));
	localparam logic signed [tas_pkg::Z_W-1:0] DEG45_Z =
		tas_pkg::Z_W'(45 << ANGLE_FRAC_BITS);
	localparam logic signed [ANG_W-1:0] DEG45  = ANG_W'(45 << ANGLE_FRAC_BITS);
	localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(90 << ANGLE_FRAC_BITS);
	localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 << ANGLE_FRAC_BITS);
	localparam logic signed [ANG_W-1:0] DEG360 = ANG_W'(360 << ANGLE_FRAC_BITS);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_RUN  = 5'b00010,
		ST_ANG  = 5'b00100,
		ST_UNF  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t                               state_q;
	tas_pkg::item_t                       item_q;
	logic signed [tas_pkg::XY_W-1:0]      x_q;
	logic signed [tas_pkg::XY_W-1:0]      y_q;
	logic signed [tas_pkg::Z_W-1:0]       z_q;
	logic [STEP_W-1:0]                    step_q;
	logic                                 swp_q;
	logic                                 small_zero_q;
	logic                                 equal_q;
	logic                                 center_q;
	logic [tas_pkg::SQ_W-1:0]             d2_q;
	logic [tas_pkg::SQ_W-1:0]             in2sq_q;
	logic [tas_pkg::SQ_W-1:0]             out2sq_q;
	logic                                 band_ok_q;
	logic signed [ANG_W-1:0]              oct_q;
	logic signed [ANG_W-1:0]              angle_q;
	logic                                 out_valid_q;
	logic signed [tas_pkg::PIX_W-1:0]     pixel_x_q;
	logic signed [tas_pkg::PIX_W-1:0]     pixel_y_q;
	logic                                 hit_q;
	logic                                 last_q;

	logic signed [tas_pkg::OFS_W-1:0]     ndx;
	logic signed [tas_pkg::OFS_W-1:0]     ndy;
	logic [tas_pkg::MAG_W-1:0]            ax;
	logic [tas_pkg::MAG_W-1:0]            ay;
	logic                                 swp;
	logic [tas_pkg::MAG_W-1:0]            big;
	logic [tas_pkg::MAG_W-1:0]            small_mag;
	logic signed [tas_pkg::XY_W-1:0]      xs;
	logic signed [tas_pkg::XY_W-1:0]      ys;
	logic signed [tas_pkg::Z_W-1:0]       at_z;
	logic signed [tas_pkg::OFS_W-1:0]     in2;
	logic [tas_pkg::MUL_W-1:0]            out2;
	logic signed [tas_pkg::MUL_W-1:0]     mul_op;
	logic signed [2*tas_pkg::MUL_W-1:0]   prod;
	logic [tas_pkg::SQ_W-1:0]             sq;
	logic signed [tas_pkg::Z_W-1:0]       zr;
	logic signed [tas_pkg::Z_W-1:0]       zc;
	logic [tas_pkg::SQ_W+1:0]             d4;
	logic                                 miss_in;
	logic                                 miss_out;
	logic signed [ANG_W-1:0]              a1;
	logic signed [ANG_W-1:0]              a2;
	logic signed [ANG_W-1:0]              a3;
	logic signed [ANG_W-1:0]              start_deg;
	logic signed [ANG_W-1:0]              sweep_deg;
	logic signed [ANG_W-1:0]              off0;
	logic signed [ANG_W-1:0]              off;
	logic                                 sweep_ok;
	logic                                 slot_free;

	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign slot_free = !out_valid_q || out_ready;

	// fold the popped offset into the first octant
	assign ndx       = -pop_item.dx;
	assign ndy       = -pop_item.dy;
	assign ax        = pop_item.dx[tas_pkg::OFS_W-1] ? ndx[tas_pkg::MAG_W-1:0]
		: pop_item.dx[tas_pkg::MAG_W-1:0];
	assign ay        = pop_item.dy[tas_pkg::OFS_W-1] ? ndy[tas_pkg::MAG_W-1:0]
		: pop_item.dy[tas_pkg::MAG_W-1:0];
	assign swp       = ay > ax;
	assign big       = swp ? ay : ax;
	assign small_mag = swp ? ax : ay;

	// one vectoring CORDIC iteration
	assign xs   = x_q >>> step_q;
	assign ys   = y_q >>> step_q;
	assign at_z = $signed({{(tas_pkg::Z_W - tas_pkg::ATAN_W){1'b0}},
		tas_pkg::atan_q16(tas_pkg::ATAN_IDX_W'(step_q))});

	// shared squarer for the band test
	assign in2  = $signed({1'b0, cfg.radius, 1'b0}) - $signed({2'b0, cfg.thickness});
	assign out2 = {2'b0, cfg.radius, 1'b0} + {3'b0, cfg.thickness};

	always_comb begin
		if (step_q == STEP_W'(0)) begin
			mul_op = {item_q.dx[tas_pkg::OFS_W-1], item_q.dx};
		end else if (step_q == STEP_W'(1)) begin
			mul_op = {item_q.dy[tas_pkg::OFS_W-1], item_q.dy};
		end else if (step_q == STEP_W'(2)) begin
			mul_op = {in2[tas_pkg::OFS_W-1], in2};
		end else begin
			mul_op = $signed(out2);
		end
	end

	assign prod = mul_op * mul_op;
	assign sq   = prod[tas_pkg::SQ_W-1:0];

	// round and clamp the octant angle
	assign zr = (z_q + RND) >>> ZSH;
	always_comb begin
		if (zr[tas_pkg::Z_W-1]) begin
			zc = '0;
		end else if (zr > DEG45_Z) begin
			zc = DEG45_Z;
		end else begin
			zc = zr;
		end
	end

	assign d4       = {d2_q, 2'b00};
	assign miss_in  = !in2[tas_pkg::OFS_W-1] && (in2 != '0) && (d4 < {2'b00, in2sq_q});
	assign miss_out = d4 > {2'b00, out2sq_q};

	// unfold the octant angle to a full turn, clockwise with y down
	assign a1 = swp_q ? DEG90 - oct_q : oct_q;
	always_comb begin
		priority if (item_q.dx[tas_pkg::OFS_W-1] && !item_q.dy[tas_pkg::OFS_W-1]) begin
			a2 = DEG180 - a1;
		end else if (item_q.dx[tas_pkg::OFS_W-1]) begin
			a2 = DEG180 + a1;
		end else if (item_q.dy[tas_pkg::OFS_W-1]) begin
			a2 = DEG360 - a1;
		end else begin
			a2 = a1;
		end
	end
	assign a3 = (a2 >= DEG360) ? a2 - DEG360 : a2;

	// sweep window test
	assign start_deg = $signed({3'b000, cfg.start_mod, {ANGLE_FRAC_BITS{1'b0}}});
	assign sweep_deg = $signed({cfg.sweep[tas_pkg::ANG_IN_W-1], cfg.sweep,
		{ANGLE_FRAC_BITS{1'b0}}});
	assign off0      = angle_q - start_deg;
	assign off       = off0[ANG_W-1] ? off0 + DEG360 : off0;
	assign sweep_ok  = off <= sweep_deg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= ((state_q == ST_OUT) && slot_free) || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= pop_item.degen ? ST_OUT : ST_RUN;
					end
				end
				ST_RUN: begin
					if (step_q == LAST_STEP) begin
						state_q <= ST_ANG;
					end
				end
				ST_ANG: state_q <= ST_UNF;
				ST_UNF: state_q <= ST_OUT;
				ST_OUT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q       <= pop_item;
			x_q          <= $signed({2'b00, big, {tas_pkg::PRESHIFT{1'b0}}});
			y_q          <= $signed({2'b00, small_mag, {tas_pkg::PRESHIFT{1'b0}}});
			z_q          <= '0;
			step_q       <= '0;
			swp_q        <= swp;
			small_zero_q <= (small_mag == '0);
			equal_q      <= (small_mag == big);
			center_q     <= (big == '0);
		end
		if (state_q == ST_RUN) begin
			step_q <= step_q + STEP_W'(1);
			if (!y_q[tas_pkg::XY_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at_z;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at_z;
			end
			if (step_q == STEP_W'(0)) begin
				d2_q <= sq;
			end else if (step_q == STEP_W'(1)) begin
				d2_q <= d2_q + sq;
			end else if (step_q == STEP_W'(2)) begin
				in2sq_q <= sq;
			end else if (step_q == STEP_W'(3)) begin
				out2sq_q <= sq;
			end
		end
		if (state_q == ST_ANG) begin
			band_ok_q <= !miss_in && !miss_out;
			if (small_zero_q) begin
				oct_q <= '0;
			end else if (equal_q) begin
				oct_q <= DEG45;
			end else begin
				oct_q <= zc[ANG_W-1:0];
			end
		end
		if (state_q == ST_UNF) begin
			angle_q <= a3;
		end
		if ((state_q == ST_OUT) && slot_free) begin
			pixel_x_q <= $signed({2'b00, cfg.center_x})
				+ $signed({item_q.dx[tas_pkg::OFS_W-1], item_q.dx});
			pixel_y_q <= $signed({2'b00, cfg.center_y})
				+ $signed({item_q.dy[tas_pkg::OFS_W-1], item_q.dy});
			hit_q     <= !item_q.degen && !center_q && band_ok_q && sweep_ok;
			last_q    <= item_q.last;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign hit       = hit_q;
	assign last      = last_q;

	`ASSERT_IMPLY(a_back_last_no_hit, clk, arst_n, out_valid_q && last_q, !hit_q)
	`ASSERT_NEXT(a_back_pop_starts, clk, arst_n, pop, (state_q == ST_RUN) || (state_q == ST_OUT))

endmodule

### src/thick_arc_pixel_scanner_core.sv
// Top level of the thick arc pixel scanner: configuration registers and block wiring.
// Each accepted request with advance set yields one result: the next offset of the scan
// square around the centre, with a hit flag for ring band and sweep window and a last flag
// on the final corner. A degenerate arc gives the centre with last set on every tick.
// A two-entry request queue decouples the scan front end from the test engine; a
// non-degenerate pixel runs the single iterative CORDIC unit and then the angle,
// unfold and output steps, while a degenerate tick goes straight to the output step.
// The result register lets the engine start the next request while a result waits.
module thick_arc_pixel_scanner_core #(
	parameter int ANGLE_FRAC_BITS = 8,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [tas_pkg::IDX_W-1:0]          cfg_index,
	input  logic [tas_pkg::DATA_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               advance,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [tas_pkg::PIX_W-1:0]   pixel_x,
	output logic signed [tas_pkg::PIX_W-1:0]   pixel_y,
	output logic                               hit,
	output logic                               last
);

	logic [tas_pkg::CX_W-1:0]            center_x_q;
	logic [tas_pkg::CX_W-1:0]            center_y_q;
	logic [tas_pkg::RAD_W-1:0]           radius_q;
	logic [tas_pkg::RAD_W-1:0]           thickness_q;
	logic [tas_pkg::START_W-1:0]         start_mod_q;
	logic signed [tas_pkg::ANG_IN_W-1:0] sweep_q;
	logic                                known_index;
	logic                                restart;
	tas_pkg::cfg_t                       cfg;
	logic                                q_full;
	logic                                q_empty;
	logic                                push;
	logic                                pop;
	tas_pkg::item_t                      push_item;
	tas_pkg::item_t                      pop_item;

	always_comb begin
		unique case (tas_pkg::reg_idx_t'(cfg_index))
			tas_pkg::REG_CENTER_X,
			tas_pkg::REG_CENTER_Y,
			tas_pkg::REG_RING_RADIUS,
			tas_pkg::REG_RING_THICKNESS,
			tas_pkg::REG_START_ANGLE,
			tas_pkg::REG_SWEEP_ANGLE: known_index = 1'b1;
			default:                  known_index = 1'b0;
		endcase
	end

	assign restart = cfg_write && known_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= '0;
			center_y_q  <= '0;
			radius_q    <= '0;
			thickness_q <= '0;
			start_mod_q <= '0;
			sweep_q     <= '0;
		end else if (cfg_write) begin
			unique case (tas_pkg::reg_idx_t'(cfg_index))
				tas_pkg::REG_CENTER_X:       center_x_q  <= cfg_data;
				tas_pkg::REG_CENTER_Y:       center_y_q  <= cfg_data;
				tas_pkg::REG_RING_RADIUS:    radius_q    <= cfg_data[tas_pkg::RAD_W-1:0];
				tas_pkg::REG_RING_THICKNESS: thickness_q <= cfg_data[tas_pkg::RAD_W-1:0];
				tas_pkg::REG_START_ANGLE:    start_mod_q <= tas_pkg::start_mod(cfg_data);
				tas_pkg::REG_SWEEP_ANGLE:    sweep_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.center_x  = center_x_q;
	assign cfg.center_y  = center_y_q;
	assign cfg.radius    = radius_q;
	assign cfg.thickness = thickness_q;
	assign cfg.start_mod = start_mod_q;
	assign cfg.sweep     = sweep_q;
	assign cfg.degen     = (sweep_q <= 0) || (radius_q == '0) || (thickness_q == '0);

	tas_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.advance   (advance),
		.cfg       (cfg),
		.restart   (restart),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	tas_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	tas_back #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.CORDIC_STEPS    (CORDIC_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.pop       (pop),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.hit       (hit),
		.last      (last)
	);

endmodule

### tb/thick_arc_pixel_scanner_core_test.sv
// Testbench of the thick arc pixel scanner core: scan prediction, handshake stress, checks.
`timescale 1ns / 100ps

module thick_arc_pixel_scanner_core_test;

	localparam int ANG_FRAC      = 8;
	localparam int CORDIC_ITERS  = 16;
	localparam int PRE_SCALE     = 24;
	localparam int ATAN_ENTRIES  = 24;
	localparam longint DEG       = longint'(1) << ANG_FRAC;
	localparam int SETTLE_CYCLES = 40;
	localparam int TOTAL_TICKS   = 1100;
	localparam int CYCLE_LIMIT   = 600000;
	localparam logic [tas_pkg::IDX_W-1:0] UNMAPPED_LO = 3'd6;
	localparam logic [tas_pkg::IDX_W-1:0] UNMAPPED_HI = 3'd7;

	typedef struct packed {
		logic signed [tas_pkg::PIX_W-1:0] px;
		logic signed [tas_pkg::PIX_W-1:0] py;
		logic                             hit;
		logic                             last;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [tas_pkg::IDX_W-1:0] cfg_index = '0;
	logic [tas_pkg::DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic advance = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [tas_pkg::PIX_W-1:0] pixel_x;
	logic signed [tas_pkg::PIX_W-1:0] pixel_y;
	logic hit;
	logic last;

	longint atan_deg_q16 [ATAN_ENTRIES] = '{
		2949120, 1740967, 919879, 466945, 234378, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	int ctr_x, ctr_y, ring_r, ring_w, start_deg, sweep_deg;
	int col_ofs, row_ofs;
	pixel_result_t pending_pixels [$];
	pixel_result_t want;
	int ticks_sent = 0;
	int fail_count = 0;
	int cycle_count = 0;
	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;

	thick_arc_pixel_scanner_core #(
		.ANGLE_FRAC_BITS(ANG_FRAC),
		.CORDIC_STEPS(CORDIC_ITERS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.advance(advance),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.hit(hit),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int scan_reach();
		return ring_r + (ring_w + 1) / 2 + 1;
	endfunction

	function automatic bit arc_is_empty();
		return sweep_deg <= 0 || ring_r == 0 || ring_w == 0;
	endfunction

	function automatic void restart_scan();
		col_ofs = -scan_reach();
		row_ofs = -scan_reach();
	endfunction

	function automatic void apply_reg(input logic [tas_pkg::IDX_W-1:0] idx,
		input logic [tas_pkg::DATA_W-1:0] data);
		case (idx)
			tas_pkg::REG_CENTER_X:       ctr_x = int'(data);
			tas_pkg::REG_CENTER_Y:       ctr_y = int'(data);
			tas_pkg::REG_RING_RADIUS:    ring_r = int'(data[tas_pkg::RAD_W-1:0]);
			tas_pkg::REG_RING_THICKNESS: ring_w = int'(data[tas_pkg::RAD_W-1:0]);
			tas_pkg::REG_START_ANGLE:    start_deg = int'($signed(data));
			tas_pkg::REG_SWEEP_ANGLE:    sweep_deg = int'($signed(data));
			default:                     return;
		endcase
		restart_scan();
	endfunction

	// angle of a first-octant vector with 0 < ay < ax
	function automatic longint octant_bearing(input longint ax, input longint ay);
		longint x, y, z, xs, ys, r;
		int i;
		x = ax <<< PRE_SCALE;
		y = ay <<< PRE_SCALE;
		z = 0;
		for (i = 0; i < CORDIC_ITERS && i < ATAN_ENTRIES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_deg_q16[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_deg_q16[i];
			end
		end
		r = (z + (longint'(1) <<< (15 - ANG_FRAC))) >>> (16 - ANG_FRAC);
		if (r < 0) r = 0;
		if (r > 45 * DEG) r = 45 * DEG;
		return r;
	endfunction

	function automatic longint arc_bearing(input int dx, input int dy);
		longint ax, ay, t, a;
		bit swapped;
		ax = dx < 0 ? -longint'(dx) : longint'(dx);
		ay = dy < 0 ? -longint'(dy) : longint'(dy);
		swapped = ay > ax;
		if (swapped) begin
			t = ax;
			ax = ay;
			ay = t;
		end
		if (ay == 0) a = 0;
		else if (ay == ax) a = 45 * DEG;
		else a = octant_bearing(ax, ay);
		if (swapped) a = 90 * DEG - a;
		if (dx < 0 && dy >= 0) a = 180 * DEG - a;
		else if (dx < 0) a = 180 * DEG + a;
		else if (dy < 0) a = 360 * DEG - a;
		if (a >= 360 * DEG) a = a - 360 * DEG;
		return a;
	endfunction

	function automatic bit ring_band_hit(input int dx, input int dy);
		longint d4, in2, out2, st, off;
		d4 = 4 * (longint'(dx) * dx + longint'(dy) * dy);
		in2 = 2 * longint'(ring_r) - ring_w;
		out2 = 2 * longint'(ring_r) + ring_w;
		if (dx == 0 && dy == 0) return 1'b0;
		if (in2 > 0 && d4 < in2 * in2) return 1'b0;
		if (d4 > out2 * out2) return 1'b0;
		st = ((start_deg % 360) + 360) % 360;
		off = arc_bearing(dx, dy) - st * DEG;
		if (off < 0) off = off + 360 * DEG;
		return off <= longint'(sweep_deg) * DEG;
	endfunction

	function automatic void next_scan_pixel();
		int reach, dx, dy;
		pixel_result_t r;
		if (arc_is_empty()) begin
			r.px = tas_pkg::PIX_W'(ctr_x);
			r.py = tas_pkg::PIX_W'(ctr_y);
			r.hit = 1'b0;
			r.last = 1'b1;
			pending_pixels.push_back(r);
			return;
		end
		reach = scan_reach();
		if (col_ofs < -reach || col_ofs > reach || row_ofs < -reach || row_ofs > reach)
			restart_scan();
		dx = col_ofs;
		dy = row_ofs;
		r.px = tas_pkg::PIX_W'(ctr_x + dx);
		r.py = tas_pkg::PIX_W'(ctr_y + dy);
		r.hit = ring_band_hit(dx, dy);
		r.last = (dx == reach && dy == reach);
		pending_pixels.push_back(r);
		if (r.last) begin
			restart_scan();
		end else if (dx == reach) begin
			col_ofs = -reach;
			row_ofs = dy + 1;
		end else begin
			col_ofs = dx + 1;
		end
	endfunction

	task automatic send_tick(input bit adv);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		advance <= adv;
		do @(posedge clk); while (!in_ready);
		if (adv) begin
			next_scan_pixel();
			ticks_sent++;
		end
	endtask

	task automatic write_reg(input logic [tas_pkg::IDX_W-1:0] idx,
		input logic [tas_pkg::DATA_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_ticks(input int count);
		repeat (count) send_tick(1'b1);
	endtask

	task automatic test_reset_state();
		send_ticks(2);
		send_tick(1'b0);
		send_tick(1'b1);
		drain_pipeline();
	endtask

	task automatic test_register_extremes();
		write_reg(tas_pkg::REG_CENTER_X, 11'd2047);
		write_reg(tas_pkg::REG_CENTER_Y, 11'd2047);
		write_reg(tas_pkg::REG_RING_RADIUS, 11'h7FF);
		write_reg(tas_pkg::REG_RING_THICKNESS, 11'd1023);
		write_reg(tas_pkg::REG_START_ANGLE, 11'(-720));
		write_reg(tas_pkg::REG_SWEEP_ANGLE, 11'd720);
		send_ticks(3);
		drain_pipeline();
		write_reg(tas_pkg::REG_CENTER_X, 11'd0);
		write_reg(tas_pkg::REG_CENTER_Y, 11'd0);
		send_ticks(2);
		drain_pipeline();
		// unmapped indexes must leave the scan position alone
		write_reg(UNMAPPED_LO, 11'h7FF);
		write_reg(UNMAPPED_HI, 11'h000);
		send_ticks(2);
		drain_pipeline();
	endtask

	task automatic test_empty_arcs();
		write_reg(tas_pkg::REG_START_ANGLE, 11'd720);
		write_reg(tas_pkg::REG_SWEEP_ANGLE, 11'(-360));
		send_ticks(2);
		drain_pipeline();
		write_reg(tas_pkg::REG_SWEEP_ANGLE, 11'd0);
		send_tick(1'b1);
		drain_pipeline();
		write_reg(tas_pkg::REG_SWEEP_ANGLE, 11'd1023);
		write_reg(tas_pkg::REG_RING_RADIUS, 11'h400);
		send_tick(1'b1);
		drain_pipeline();
		write_reg(tas_pkg::REG_RING_RADIUS, 11'd5);
		write_reg(tas_pkg::REG_RING_THICKNESS, 11'd0);
		send_tick(1'b1);
		drain_pipeline();
		write_reg(tas_pkg::REG_RING_THICKNESS, 11'd1);
		write_reg(tas_pkg::REG_START_ANGLE, 11'h400);
		send_ticks(2);
		drain_pipeline();
	endtask

	task automatic test_random_scans();
		int kind, r, t, s, w, reach, pass_len, done;
		while (ticks_sent < TOTAL_TICKS) begin
			drain_pipeline();
			send_steady = ($urandom_range(0, 3) == 0);
			recv_steady = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			s = ($urandom_range(0, 7) == 0) ? int'($signed(11'($urandom))) :
				$urandom_range(0, 1440) - 720;
			w = ($urandom_range(0, 7) == 0) ? int'($signed(11'($urandom))) :
				$urandom_range(1, 720);
			if (kind < 6) begin
				r = $urandom_range(1, 3);
				t = $urandom_range(1, 4);
				reach = r + (t + 1) / 2 + 1;
				pass_len = (2 * reach + 1) * (2 * reach + 1) + $urandom_range(0, 8);
			end else if (kind < 8) begin
				r = $urandom_range(0, 1023);
				t = $urandom_range(0, 1023);
				pass_len = $urandom_range(4, 30);
			end else begin
				r = $urandom_range(0, 3);
				t = $urandom_range(0, 4);
				w = -$urandom_range(0, 360);
				pass_len = $urandom_range(2, 12);
			end
			write_reg(tas_pkg::REG_CENTER_X, 11'($urandom_range(0, 2047)));
			write_reg(tas_pkg::REG_CENTER_Y, 11'($urandom_range(0, 2047)));
			write_reg(tas_pkg::REG_RING_RADIUS, {1'($urandom), 10'(r)});
			write_reg(tas_pkg::REG_RING_THICKNESS, {1'($urandom), 10'(t)});
			write_reg(tas_pkg::REG_START_ANGLE, 11'(s));
			write_reg(tas_pkg::REG_SWEEP_ANGLE, 11'(w));
			if ($urandom_range(0, 4) == 0)
				write_reg($urandom_range(0, 1) ? UNMAPPED_HI : UNMAPPED_LO, 11'($urandom));
			done = 0;
			while (done < pass_len) begin
				if ($urandom_range(0, 9) == 0) begin
					send_tick(1'b0);
				end else begin
					send_tick(1'b1);
					done++;
				end
			end
		end
		drain_pipeline();
	endtask

	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		forever begin
			stall = recv_steady ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$error("unexpected result: pixel_x %0d pixel_y %0d", pixel_x, pixel_y);
				fail_count++;
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_x !== want.px) begin
					$error("pixel_x: expected %0d, got %0d", want.px, pixel_x);
					fail_count++;
				end
				if (pixel_y !== want.py) begin
					$error("pixel_y: expected %0d, got %0d", want.py, pixel_y);
					fail_count++;
				end
				if (hit !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, hit);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					fail_count++;
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("thick_arc_pixel_scanner_core verification failed");
		$finish;
	end

	initial begin
		ctr_x = 0;
		ctr_y = 0;
		ring_r = 0;
		ring_w = 0;
		start_deg = 0;
		sweep_deg = 0;
		restart_scan();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_register_extremes();
		test_empty_arcs();
		test_random_scans();
		if (fail_count == 0)
			$display("thick_arc_pixel_scanner_core verification clean");
		else
			$display("thick_arc_pixel_scanner_core verification failed");
		$finish;
	end

endmodule
